// ----- hdl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- hdl/mme_pkg.sv -----
// package: types, constants and arithmetic helpers of the modulation matrix engine
package mme_pkg;
  localparam int NUM_SOURCES_DEF = 32;
  localparam int NUM_DESTS_DEF = 32;
  localparam int FIXED_ROUTES_DEF = 10;
  localparam int MATRIX_ROUTES_DEF = 16;
  localparam int ROUTE_DEPTH = 32;
  localparam int TUNE_DEPTH = 16;

  localparam logic [1:0] OP_SRC = 2'd0;
  localparam logic [1:0] OP_ROUTE = 2'd1;
  localparam logic [1:0] OP_TUNE = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  localparam logic signed [23:0] QMAX = 24'sh7fffff;
  localparam logic signed [23:0] QMIN = -24'sh800000;
  localparam logic signed [23:0] QONE = 24'sd65536;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] slot;
    logic signed [23:0] sample_value;
    logic [4:0] route_source;
    logic [4:0] route_via_source;
    logic signed [23:0] route_via_amount;
    logic signed [23:0] route_amount;
    logic [4:0] route_dest;
  } in_item_t;

  typedef struct packed {
    logic [4:0] dest_index;
    logic signed [23:0] dest_value;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic [4:0] src;
    logic [4:0] via;
    logic signed [23:0] via_amt;
    logic signed [23:0] amt;
    logic [4:0] dst;
  } route_t;

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    logic signed [23:0] r;
    if (v > 50'sd8388607) r = QMAX;
    else if (v < -50'sd8388608) r = QMIN;
    else r = v[23:0];
    return r;
  endfunction

  // round half up, floor shift, saturate
  function automatic logic signed [23:0] qround(input logic signed [47:0] p);
    logic signed [48:0] s;
    s = 49'(p) + 49'sd32768;
    return sat24(50'(s >>> 16));
  endfunction

  function automatic route_t fixed_route(input logic [4:0] i);
    route_t r;
    r = '0;
    case (i)
      5'd0: begin r.src = 5'd1; r.amt = 24'sd5461; r.dst = 5'd0; end
      5'd1: begin r.src = 5'd2; r.amt = 24'sd1092; r.dst = 5'd0; end
      5'd2: begin r.src = 5'd2; r.amt = 24'sd32768; r.dst = 5'd1; end
      5'd3: begin r.src = 5'd3; r.amt = 24'sd65536; r.dst = 5'd16; end
      5'd4: begin r.src = 5'd3; r.amt = 24'sd65536; r.dst = 5'd17; end
      5'd5: begin r.src = 5'd4; r.dst = 5'd16; end
      5'd6: begin r.src = 5'd4; r.dst = 5'd17; end
      5'd7: begin r.src = 5'd5; r.dst = 5'd4; end
      5'd8: begin r.src = 5'd6; r.dst = 5'd5; end
      5'd9: begin r.src = 5'd7; r.dst = 5'd6; end
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ----- hdl/modulation_matrix_engine.sv -----
// top level: modulation matrix engine sequencer and datapath
// write transactions are accepted in idle; a compute transaction clears the 32 accumulators, applies 13 tuning
// terms, evaluates each active route (26 by default), runs 12 folds and emits one result
// per destination, with the input stalled meanwhile
// reset: synchronous; a sweep loads the route defaults and clears the source and
// tuning memories, during which no transaction is accepted
`include "assert_macros.svh"
module modulation_matrix_engine #(
  parameter int NUM_SOURCES = mme_pkg::NUM_SOURCES_DEF,
  parameter int NUM_DESTS = mme_pkg::NUM_DESTS_DEF,
  parameter int FIXED_ROUTES = mme_pkg::FIXED_ROUTES_DEF,
  parameter int MATRIX_ROUTES = mme_pkg::MATRIX_ROUTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  mme_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output mme_pkg::out_item_t out_data
);
  localparam int ACTIVE = (FIXED_ROUTES + MATRIX_ROUTES > 32) ? 32
                        : FIXED_ROUTES + MATRIX_ROUTES;

  // state codes
  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_TUNE = 4'd2, S_TUNE_W = 4'd3,
    S_RT_RD = 4'd4, S_RT_SRC = 4'd5, S_RT_VIA = 4'd6, S_RT_M1 = 4'd7, S_RT_M2 = 4'd8,
    S_RT_ACC = 4'd9, S_FOLD = 4'd10, S_FOLD_W = 4'd11, S_EMIT = 4'd12, S_EMIT_W = 4'd13,
    S_INIT = 4'd14;

  logic [3:0] state;
  logic [5:0] cnt;
  logic [5:0] init_cnt;
  logic rt_busy;

  // memory ports
  logic src_we, tun_we, acc_we;
  logic [4:0] src_wa, src_ra, acc_wa, acc_ra;
  logic [3:0] tun_wa, tun_ra;
  logic signed [23:0] src_wd, tun_wd, acc_wd, src_rd, tun_rd, acc_rd;
  logic rt_we;
  mme_pkg::route_t rt_rd, rt_wd;
  logic [4:0] rt_ra;

  // datapath registers
  mme_pkg::route_t route;
  logic signed [23:0] s_val, v_val, m_val, term, fold_val;
  logic src_zero;
  logic [4:0] dst;
  logic dst_ok;
  logic signed [23:0] mul_a, mul_b;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  // tuning term tables: destination and coefficient; terms 3 to 5 are added directly
  function automatic logic [4:0] tune_dst(input logic [3:0] i);
    logic [4:0] d;
    case (i)
      4'd0, 4'd1, 4'd2: d = 5'd4 + 5'(i);
      4'd3, 4'd4, 4'd5: d = 5'd4 + 5'(i);
      4'd6: d = 5'd17;
      default: d = 5'd11 + 5'(i);
    endcase
    return d;
  endfunction
  function automatic logic signed [23:0] tune_k(input logic [3:0] i);
    logic signed [23:0] k;
    case (i)
      4'd0, 4'd1, 4'd2: k = 24'sd2731;
      4'd3, 4'd4, 4'd5: k = 24'sd65536;
      4'd6: k = 24'sd131072;
      default: k = 24'sd19661;
    endcase
    return k;
  endfunction

  // fold order: all-pitch 1->7.., 0->4.., 2->10.., 3->13..
  function automatic logic [4:0] fold_all(input logic [3:0] f);
    logic [4:0] a;
    case (f)
      4'd0, 4'd1, 4'd2: a = 5'd1;
      4'd3, 4'd4, 4'd5: a = 5'd0;
      4'd6, 4'd7, 4'd8: a = 5'd2;
      default: a = 5'd3;
    endcase
    return a;
  endfunction
  // per-oscillator destination of fold step f
  function automatic logic [4:0] fold_dst(input logic [3:0] f);
    logic [4:0] a;
    case (f)
      4'd0, 4'd1, 4'd2: a = 5'd7 + 5'(f);
      4'd3, 4'd4, 4'd5: a = 5'd1 + 5'(f);
      default: a = 5'd4 + 5'(f);
    endcase
    return a;
  endfunction

  mme_route_mem u_rt (.clk, .rst, .we(rt_we), .waddr(in_data.slot), .wdata(rt_wd),
    .raddr(rt_ra), .rdata(rt_rd), .busy(rt_busy));
  mme_vec_mem #(.DEPTH(32)) u_src (.clk, .we(src_we), .waddr(src_wa), .wdata(src_wd),
    .raddr(src_ra), .rdata(src_rd));
  mme_vec_mem #(.DEPTH(16)) u_tun (.clk, .we(tun_we), .waddr(tun_wa), .wdata(tun_wd),
    .raddr(tun_ra), .rdata(tun_rd));
  mme_vec_mem #(.DEPTH(32)) u_acc (.clk, .we(acc_we), .waddr(acc_wa), .wdata(acc_wd),
    .raddr(acc_ra), .rdata(acc_rd));

  assign rt_wd = '{src: in_data.route_source, via: in_data.route_via_source,
    via_amt: in_data.route_via_amount, amt: in_data.route_amount, dst: in_data.route_dest};
  assign rt_we = accept && in_data.opcode == mme_pkg::OP_ROUTE;
  assign rt_ra = cnt[4:0];

  // one shared multiplier, operands picked by state
  always_comb begin
    mul_a = s_val;
    mul_b = tune_k(cnt[3:0]);
    case (state)
      S_TUNE_W: begin mul_a = tun_rd; mul_b = tune_k(cnt[3:0]); end
      S_RT_M1:  begin mul_a = v_val; mul_b = route.via_amt; end
      S_RT_M2:  begin mul_a = s_val; mul_b = m_val; end
      S_RT_ACC: begin mul_a = term; mul_b = route.amt; end
      default: ;
    endcase
  end

  // source read value with the special indices
  function automatic logic signed [23:0] src_fix(input logic [4:0] i,
                                               input logic signed [23:0] d);
    logic signed [23:0] r;
    if (i == 5'd0) r = mme_pkg::QONE;
    else if (32'(i) >= NUM_SOURCES) r = '0;
    else r = d;
    return r;
  endfunction

  // memory write/read control
  always_comb begin
    src_we = 1'b0; src_wa = in_data.slot; src_wd = in_data.sample_value;
    tun_we = 1'b0; tun_wa = in_data.slot[3:0]; tun_wd = in_data.sample_value;
    acc_we = 1'b0; acc_wa = dst; acc_wd = '0;
    src_ra = route.src; tun_ra = cnt[3:0]; acc_ra = dst;
    case (state)
      S_INIT: begin
        src_we = 1'b1; src_wa = init_cnt[4:0]; src_wd = '0;
        tun_we = 1'b1; tun_wa = init_cnt[3:0]; tun_wd = '0;
      end
      S_IDLE: begin
        src_we = accept && in_data.opcode == mme_pkg::OP_SRC && in_data.slot != 5'd0
                 && 32'(in_data.slot) < NUM_SOURCES;
        tun_we = accept && in_data.opcode == mme_pkg::OP_TUNE && !in_data.slot[4];
      end
      S_CLR: begin acc_we = 1'b1; acc_wa = cnt[4:0]; end
      S_TUNE: acc_ra = tune_dst(cnt[3:0]);
      S_TUNE_W: begin
        acc_wa = tune_dst(cnt[3:0]);
        acc_we = 1'b1;
        acc_wd = mme_pkg::sat24(50'(acc_rd) + 50'((cnt[3:0] >= 4'd3 && cnt[3:0] <= 4'd5)
                 ? tun_rd : mme_pkg::qround(mul_a * mul_b)));
      end
      S_RT_SRC: src_ra = rt_rd.src;
      S_RT_VIA: src_ra = route.via;
      S_RT_ACC: begin
        acc_we = dst_ok;
        acc_wd = mme_pkg::sat24(50'(acc_rd) + 50'(mme_pkg::qround(mul_a * mul_b)));
      end
      S_FOLD: acc_ra = fold_all(cnt[3:0]);
      S_FOLD_W: begin
        acc_ra = dst;
        acc_we = (ph == 2'd2);
        acc_wd = mme_pkg::sat24(50'(acc_rd) + 50'(fold_val));
      end
      S_EMIT: acc_ra = cnt[4:0];
      default: ;
    endcase
  end

  logic [1:0] ph;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_cnt <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
      ph <= '0;
      src_zero <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 6'd1;
          if (init_cnt[5] && !rt_busy) state <= S_IDLE;
        end
        S_IDLE: if (accept && in_data.opcode == mme_pkg::OP_COMPUTE) begin
          state <= S_CLR; cnt <= '0;
        end
        S_CLR: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin state <= S_TUNE; cnt <= '0; end
        end
        S_TUNE: begin dst <= tune_dst(cnt[3:0]); state <= S_TUNE_W; ph <= '0; end
        S_TUNE_W: begin
          // acc and tuning reads issued in S_TUNE are valid here
          if (cnt == 6'd12) begin state <= S_RT_RD; cnt <= '0; end
          else begin cnt <= cnt + 6'd1; state <= S_TUNE; end
        end
        S_RT_RD: state <= S_RT_SRC;
        S_RT_SRC: begin route <= rt_rd; state <= S_RT_VIA; end
        S_RT_VIA: begin
          s_val <= src_fix(route.src, src_rd);
          dst <= route.dst; dst_ok <= 32'(route.dst) < NUM_DESTS;
          state <= S_RT_M1;
        end
        S_RT_M1: begin
          if (!src_zero) v_val <= src_fix(route.via, src_rd);
          src_zero <= 1'b1;
          if (src_zero) begin
            m_val <= mme_pkg::sat24(50'(mme_pkg::sat24(50'(mme_pkg::QONE) -
                     50'(route.via_amt))) + 50'(mme_pkg::qround(mul_a * mul_b)));
            state <= S_RT_M2; src_zero <= 1'b0;
          end
        end
        S_RT_M2: begin
          if (!src_zero) begin term <= mme_pkg::qround(mul_a * mul_b); src_zero <= 1'b1; end
          else begin src_zero <= 1'b0; state <= S_RT_ACC; end
        end
        S_RT_ACC: begin
          if (32'(cnt) == ACTIVE - 1) begin state <= S_FOLD; cnt <= '0; end
          else begin cnt <= cnt + 6'd1; state <= S_RT_RD; end
        end
        S_FOLD: begin
          state <= S_FOLD_W; ph <= 2'd0;
          dst <= fold_dst(cnt[3:0]);
        end
        S_FOLD_W: begin
          // ph0: all value read done, ph1: dest read done, ph2: write
          ph <= ph + 2'd1;
          if (ph == 2'd0) fold_val <= acc_rd;
          if (ph == 2'd2) begin
            if (cnt == 6'd11) begin state <= S_EMIT; cnt <= '0; end
            else begin cnt <= cnt + 6'd1; state <= S_FOLD; end
          end
        end
        // a held result is cleared below once it is taken
        S_EMIT: if (!out_valid || !out_stall) begin
          state <= S_EMIT_W;
        end
        S_EMIT_W: begin
          out_valid <= 1'b1;
          out_data.dest_index <= cnt[4:0];
          out_data.dest_value <= acc_rd;
          out_data.last <= (32'(cnt) == NUM_DESTS - 1);
          if (32'(cnt) == NUM_DESTS - 1) state <= S_IDLE;
          else begin cnt <= cnt + 6'd1; state <= S_EMIT; end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state != S_EMIT_W) out_valid <= 1'b0;
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall)
  `ASSERT_NEXT(a_emit_valid, clk, rst, state == S_EMIT_W, out_valid)
  `ASSERT_IMPL(a_last_ends, clk, rst, out_valid && out_data.last && state == S_EMIT_W,
    1'b0)
endmodule

// ----- hdl/mme_route_mem.sv -----
// route memory with reset sweep to the fixed defaults
module mme_route_mem (
  input  logic clk,
  input  logic rst,
  input  logic we,
  input  logic [4:0] waddr,
  input  mme_pkg::route_t wdata,
  input  logic [4:0] raddr,
  output mme_pkg::route_t rdata,
  output logic busy
);
  mme_pkg::route_t mem [mme_pkg::ROUTE_DEPTH];
  logic [5:0] sweep;

  always_ff @(posedge clk) begin
    if (rst) sweep <= '0;
    else if (!sweep[5]) sweep <= sweep + 6'd1;
  end
  assign busy = !sweep[5];

  always_ff @(posedge clk) begin
    if (busy) mem[sweep[4:0]] <= mme_pkg::fixed_route(sweep[4:0]);
    else if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/mme_vec_mem.sv -----
// generic 24-bit memory, one write and one registered read port
module mme_vec_mem #(
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic signed [23:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic signed [23:0] rdata
);
  logic signed [23:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
